// ===== rtl/apsq_pkg.sv =====
// Package: shared types and codes for the alarm panel sequencer.
package apsq_pkg;

  // Event kinds
  localparam logic [1:0] EV_SMS  = 2'd0;
  localparam logic [1:0] EV_CTRL = 2'd1;
  localparam logic [1:0] EV_NEW  = 2'd2;
  localparam logic [1:0] EV_NONE = 2'd3;

  // Response codes
  localparam logic [1:0] RESP_CONT = 2'd0;
  localparam logic [1:0] RESP_OK   = 2'd1;
  localparam logic [1:0] RESP_ERR  = 2'd2;

  // Siren commands
  localparam logic [1:0] SIREN_NONE  = 2'd0;
  localparam logic [1:0] SIREN_MULTI = 2'd1;
  localparam logic [1:0] SIREN_STOP  = 2'd2;
  localparam logic [1:0] SIREN_CHOP  = 2'd3;

  // Speak vectors
  localparam logic [1:0] VEC_NONE = 2'd0;
  localparam logic [1:0] VEC_A    = 2'd1;
  localparam logic [1:0] VEC_B    = 2'd2;

  // Remote buttons
  localparam logic [7:0] BTN_1 = 8'd1;
  localparam logic [7:0] BTN_2 = 8'd2;
  localparam logic [7:0] BTN_3 = 8'd3;
  localparam logic [7:0] BTN_4 = 8'd4;

  // Positions
  localparam logic [9:0]  SMS_POSITION = 10'd911;
  localparam logic [15:0] MAX_POSITION = 16'd1023;

  // Configuration register indexes
  localparam logic [7:0] CFG_ARM_DELAY  = 8'd0;
  localparam logic [7:0] CFG_B1_REPEATS = 8'd1;
  localparam logic [7:0] CFG_B3_REPEATS = 8'd2;
  localparam logic [7:0] CFG_B1_TIMEOUT = 8'd3;
  localparam logic [7:0] CFG_B2_TIMEOUT = 8'd4;
  localparam logic [7:0] CFG_B3_TIMEOUT = 8'd5;
  localparam logic [7:0] CFG_AUDIO_EN   = 8'd6;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] position;
    logic [7:0]  button;
    logic        audio_idle;
    logic        second_tick;
  } apsq_in_t;

  typedef struct packed {
    logic [1:0] response;
    logic       floodlight_on;
    logic       aux5_on;
    logic [1:0] siren_cmd;
    logic [1:0] speak_vector;
    logic       speak_position_valid;
    logic [9:0] speak_position;
  } apsq_out_t;

endpackage

// ===== rtl/alarm_panel_sequencer_unit.sv =====
// Top level: alarm panel sequencer, one result transaction per input transaction.
//
// Each input transaction is one poll of the alarm sequence and produces exactly one
// result transaction. A poll is held in an input register, evaluated by the sequence
// state machine and lands in a result register. A new poll is taken every clock cycle
// as long as results are drained; that rate is set by the state machine update, which
// must finish before the next poll is evaluated. Configuration registers are written
// through the cfg_ channel (always ready) and should only be changed while no poll
// is in flight.
module alarm_panel_sequencer_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  apsq_pkg::apsq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output apsq_pkg::apsq_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import apsq_pkg::*;

  typedef enum logic [4:0] {
    S_START, S_B1, S_B1_A, S_B1_B, S_B1_C, S_B1_D, S_B1_FIN, S_B1_FIN_B,
    S_B2, S_B2_A, S_B2_B, S_B2_C, S_B2_D, S_B2_E, S_B2_FIN,
    S_B3, S_B3_A, S_B3_B, S_B3_C, S_B3_D, S_B3_FIN, S_B3_FIN_B,
    S_B4, S_B4_A, S_B4_FIN
  } seq_state_t;

  // Configuration registers
  logic [7:0] arm_delay_r, b1_repeats_r, b3_repeats_r;
  logic [7:0] b1_timeout_r, b2_timeout_r, b3_timeout_r;
  logic [1:0] audio_en_r;

  // Sequence state
  seq_state_t st_r, st_nxt;
  logic [9:0] mpos_r, mpos_nxt;
  logic [7:0] rep_r, rep_nxt;
  logic [7:0] sec_r, sec_nxt, sec_step;
  logic       flood_r, flood_nxt;
  logic       aux_r, aux_nxt;

  // Pipeline registers
  logic       s1_valid_r;
  apsq_in_t   s1_data_r;
  logic       out_valid_r;
  apsq_out_t  out_data_r;
  apsq_out_t  res;
  logic       advance;

  // Per-poll result fields
  logic [1:0] resp, siren, vec;
  logic       spk;
  logic [9:0] spk_pos;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_delay_r  <= 8'd2;
      b1_repeats_r <= 8'd3;
      b3_repeats_r <= 8'd3;
      b1_timeout_r <= 8'd60;
      b2_timeout_r <= 8'd60;
      b3_timeout_r <= 8'd60;
      audio_en_r   <= 2'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ARM_DELAY:  arm_delay_r  <= cfg_data;
        CFG_B1_REPEATS: b1_repeats_r <= cfg_data;
        CFG_B3_REPEATS: b3_repeats_r <= cfg_data;
        CFG_B1_TIMEOUT: b1_timeout_r <= cfg_data;
        CFG_B2_TIMEOUT: b2_timeout_r <= cfg_data;
        CFG_B3_TIMEOUT: b3_timeout_r <= cfg_data;
        CFG_AUDIO_EN:   audio_en_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Sequence step for the poll held in the input register
  always_comb begin
    st_nxt    = st_r;
    mpos_nxt  = mpos_r;
    rep_nxt   = rep_r;
    sec_step  = sec_r;
    flood_nxt = flood_r;
    aux_nxt   = aux_r;
    resp      = RESP_CONT;
    siren     = SIREN_NONE;
    vec       = VEC_NONE;
    spk       = 1'b0;
    spk_pos   = 10'd0;

    unique case (st_r)
      S_START: begin
        if (s1_data_r.event_kind == EV_SMS) begin
          mpos_nxt = SMS_POSITION;
          rep_nxt  = b1_repeats_r;
          sec_step = arm_delay_r;
          st_nxt   = S_B1;
        end else if (s1_data_r.event_kind == EV_CTRL &&
                     s1_data_r.position <= MAX_POSITION) begin
          case (s1_data_r.button)
            BTN_1: begin
              mpos_nxt = s1_data_r.position[9:0];
              rep_nxt  = b1_repeats_r;
              sec_step = arm_delay_r;
              st_nxt   = S_B1;
            end
            BTN_2: begin
              sec_step = arm_delay_r;
              st_nxt   = S_B2;
            end
            BTN_3: begin
              mpos_nxt = s1_data_r.position[9:0];
              rep_nxt  = b3_repeats_r;
              sec_step = arm_delay_r;
              st_nxt   = S_B3;
            end
            BTN_4: begin
              sec_step = arm_delay_r;
              st_nxt   = S_B4;
            end
            default: resp = RESP_ERR;
          endcase
        end else begin
          resp = RESP_ERR;
        end
      end
      S_B1: begin
        flood_nxt = 1'b1;
        aux_nxt   = 1'b1;
        siren     = SIREN_MULTI;
        st_nxt    = S_B1_A;
      end
      S_B1_A: begin
        if (sec_r == 8'd0) begin
          sec_step = b1_timeout_r;
          st_nxt   = S_B1_B;
        end
      end
      S_B3_A: begin
        if (sec_r == 8'd0) begin
          sec_step = b3_timeout_r;
          st_nxt   = S_B3_B;
        end
      end
      S_B1_B: begin
        // cancel and timeout together skip past the finish step
        if (s1_data_r.event_kind == EV_NEW && s1_data_r.button == BTN_1)
          st_nxt = (sec_r == 8'd0) ? S_B1_FIN_B : S_B1_FIN;
        else if (sec_r == 8'd0)
          st_nxt = S_B1_C;
      end
      S_B1_C: begin
        if (rep_r > 8'd1) begin
          rep_nxt = rep_r - 8'd1;
          siren   = SIREN_STOP;
          if (audio_en_r[0]) vec = VEC_A;
          spk     = 1'b1;
          spk_pos = mpos_r;
          st_nxt  = S_B1_D;
        end else begin
          st_nxt = S_B1_FIN;
        end
      end
      S_B3_C: begin
        if (rep_r > 8'd1) begin
          rep_nxt = rep_r - 8'd1;
          siren   = SIREN_STOP;
          if (audio_en_r[1]) vec = VEC_B;
          spk     = 1'b1;
          spk_pos = mpos_r;
          st_nxt  = S_B3_D;
        end else begin
          st_nxt = S_B3_FIN;
        end
      end
      S_B1_D: begin
        if (s1_data_r.audio_idle) st_nxt = S_B1;
      end
      S_B1_FIN: begin
        siren     = SIREN_STOP;
        flood_nxt = 1'b0;
        aux_nxt   = 1'b0;
        spk       = 1'b1;
        spk_pos   = mpos_r;
        st_nxt    = S_B1_FIN_B;
      end
      S_B1_FIN_B, S_B3_FIN_B: begin
        if (s1_data_r.audio_idle) resp = RESP_OK;
      end
      S_B2: begin
        flood_nxt = 1'b1;
        st_nxt    = S_B2_A;
      end
      S_B2_A: st_nxt = S_B2_B;
      S_B2_B: begin
        if (sec_r == 8'd0) begin
          sec_step = b2_timeout_r;
          st_nxt   = S_B2_C;
        end
      end
      S_B2_C: begin
        if (s1_data_r.event_kind == EV_SMS) begin
          mpos_nxt = SMS_POSITION;
          rep_nxt  = b1_repeats_r;
          sec_step = arm_delay_r;
          st_nxt   = S_B1;
        end else if (s1_data_r.event_kind == EV_NEW) begin
          case (s1_data_r.button)
            BTN_2: st_nxt = S_B2_FIN;
            BTN_1: begin
              mpos_nxt = s1_data_r.position[9:0];
              rep_nxt  = b1_repeats_r;
              sec_step = arm_delay_r;
              st_nxt   = S_B1;
            end
            BTN_3: begin
              mpos_nxt = s1_data_r.position[9:0];
              rep_nxt  = b3_repeats_r;
              sec_step = arm_delay_r;
              st_nxt   = S_B3;
            end
            default: ;
          endcase
        end
        // timeout test sees the timer as just reloaded
        if (sec_step == 8'd0) st_nxt = S_B2_FIN;
      end
      S_B2_D: begin
        siren   = SIREN_STOP;
        spk     = 1'b1;
        spk_pos = mpos_r;
        st_nxt  = S_B2_E;
      end
      S_B4: begin
        siren   = SIREN_STOP;
        spk     = 1'b1;
        spk_pos = mpos_r;
        st_nxt  = S_B4_A;
      end
      S_B2_E: begin
        if (s1_data_r.audio_idle) st_nxt = S_B2_FIN;
      end
      S_B4_A: begin
        if (s1_data_r.audio_idle) st_nxt = S_B4_FIN;
      end
      S_B2_FIN: begin
        flood_nxt = 1'b0;
        resp      = RESP_OK;
      end
      S_B3: begin
        flood_nxt = 1'b1;
        siren     = SIREN_CHOP;
        st_nxt    = S_B3_A;
      end
      S_B3_B: begin
        if (s1_data_r.event_kind == EV_SMS) begin
          mpos_nxt = SMS_POSITION;
          rep_nxt  = b1_repeats_r;
          sec_step = arm_delay_r;
          st_nxt   = S_B1;
        end else if (s1_data_r.event_kind == EV_NEW) begin
          if (s1_data_r.button == BTN_3) begin
            st_nxt = S_B3_FIN;
          end else if (s1_data_r.button == BTN_1) begin
            mpos_nxt = s1_data_r.position[9:0];
            rep_nxt  = b1_repeats_r;
            sec_step = arm_delay_r;
            st_nxt   = S_B1;
          end
        end
        // timeout advances one past the state just chosen
        if (sec_step == 8'd0) begin
          case (st_nxt)
            S_B1:     st_nxt = S_B1_A;
            S_B3_FIN: st_nxt = S_B3_FIN_B;
            default:  st_nxt = S_B3_C;
          endcase
        end
      end
      S_B3_D: begin
        if (s1_data_r.audio_idle) st_nxt = S_B3;
      end
      S_B3_FIN: begin
        siren     = SIREN_STOP;
        flood_nxt = 1'b0;
        spk       = 1'b1;
        spk_pos   = mpos_r;
        st_nxt    = S_B3_FIN_B;
      end
      S_B4_FIN: resp = RESP_OK;
      default:  st_nxt = S_START;
    endcase

    // seconds timer, saturating at zero
    sec_nxt = (s1_data_r.second_tick && sec_step != 8'd0) ? sec_step - 8'd1 : sec_step;

    res.response             = resp;
    res.floodlight_on        = flood_nxt;
    res.aux5_on              = aux_nxt;
    res.siren_cmd            = siren;
    res.speak_vector         = vec;
    res.speak_position_valid = spk;
    res.speak_position       = spk_pos;
  end

  // Sequence state, input register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_START;
      mpos_r      <= 10'd0;
      rep_r       <= 8'd0;
      sec_r       <= 8'd0;
      flood_r     <= 1'b0;
      aux_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        st_r    <= st_nxt;
        mpos_r  <= mpos_nxt;
        rep_r   <= rep_nxt;
        sec_r   <= sec_nxt;
        flood_r <= flood_nxt;
        aux_r   <= aux_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

endmodule

// ===== tb/sv/alarm_panel_sequencer_unit_tb.sv =====
// Testbench for the alarm panel sequencer: random polls checked against a local sequence model.
`timescale 1ns / 100ps

module alarm_panel_sequencer_unit_tb;
  import apsq_pkg::*;

  // Sequence states of the local model
  typedef enum logic [4:0] {
    PS_START, PS_B1, PS_B1_A, PS_B1_B, PS_B1_C, PS_B1_D, PS_B1_FIN, PS_B1_FIN_B,
    PS_B2, PS_B2_A, PS_B2_B, PS_B2_C, PS_B2_D, PS_B2_E, PS_B2_FIN,
    PS_B3, PS_B3_A, PS_B3_B, PS_B3_C, PS_B3_D, PS_B3_FIN, PS_B3_FIN_B,
    PS_B4, PS_B4_A, PS_B4_FIN
  } panel_state_t;

  // Register indexes with nothing behind them
  localparam logic [7:0] CFG_UNMAPPED  = 8'd7;
  localparam logic [7:0] CFG_TOP_INDEX = 8'd255;

  localparam int PHASE_POLLS = 385;
  localparam int QUIET_LIMIT = 2000;
  localparam int END_CYCLES  = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  apsq_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  apsq_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  alarm_panel_sequencer_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Model state and register copy
  panel_state_t panel_state = PS_START;
  logic [9:0] main_position = '0;
  logic [7:0] repeats_left = '0;
  logic [7:0] seconds_left = '0;
  logic flood_level = 1'b0;
  logic aux5_level = 1'b0;
  logic [7:0] panel_cfg [0:255];

  apsq_in_t pending_polls [$];
  apsq_out_t expected_results [$];
  apsq_out_t want_result;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  int phase;
  int n;
  int entry_roll;
  logic [6:0][7:0] phase_regs;

  function automatic void arm_button1(input logic [9:0] pos);
    main_position = pos;
    repeats_left = panel_cfg[CFG_B1_REPEATS];
    seconds_left = panel_cfg[CFG_ARM_DELAY];
    panel_state = PS_B1;
  endfunction

  function automatic void arm_button3(input logic [9:0] pos);
    main_position = pos;
    repeats_left = panel_cfg[CFG_B3_REPEATS];
    seconds_left = panel_cfg[CFG_ARM_DELAY];
    panel_state = PS_B3;
  endfunction

  // One poll of the sequence: advances the model and returns the result
  function automatic apsq_out_t panel_step(input apsq_in_t poll);
    apsq_out_t r;
    logic new_code;
    logic sms;
    new_code = (poll.event_kind == EV_NEW);
    sms = (poll.event_kind == EV_SMS);
    r = '0;
    r.response = RESP_CONT;
    r.siren_cmd = SIREN_NONE;
    r.speak_vector = VEC_NONE;
    case (panel_state)
      PS_START: begin
        if (sms) begin
          arm_button1(SMS_POSITION);
        end else if (poll.event_kind == EV_CTRL && poll.position <= MAX_POSITION) begin
          if (poll.button == BTN_1) begin
            arm_button1(poll.position[9:0]);
          end else if (poll.button == BTN_2) begin
            seconds_left = panel_cfg[CFG_ARM_DELAY];
            panel_state = PS_B2;
          end else if (poll.button == BTN_3) begin
            arm_button3(poll.position[9:0]);
          end else if (poll.button == BTN_4) begin
            seconds_left = panel_cfg[CFG_ARM_DELAY];
            panel_state = PS_B4;
          end else begin
            r.response = RESP_ERR;
          end
        end else begin
          r.response = RESP_ERR;
        end
      end
      PS_B1: begin
        flood_level = 1'b1;
        aux5_level = 1'b1;
        r.siren_cmd = SIREN_MULTI;
        panel_state = PS_B1_A;
      end
      PS_B1_A: begin
        if (seconds_left == 0) begin
          seconds_left = panel_cfg[CFG_B1_TIMEOUT];
          panel_state = PS_B1_B;
        end
      end
      PS_B3_A: begin
        if (seconds_left == 0) begin
          seconds_left = panel_cfg[CFG_B3_TIMEOUT];
          panel_state = PS_B3_B;
        end
      end
      // timeout advances one step from whatever the event just chose
      PS_B1_B: begin
        if (new_code && poll.button == BTN_1) panel_state = PS_B1_FIN;
        if (seconds_left == 0)
          panel_state = (panel_state == PS_B1_FIN) ? PS_B1_FIN_B : PS_B1_C;
      end
      PS_B1_C: begin
        if (repeats_left > 1) begin
          repeats_left--;
          r.siren_cmd = SIREN_STOP;
          if (panel_cfg[CFG_AUDIO_EN][0]) r.speak_vector = VEC_A;
          r.speak_position_valid = 1'b1;
          r.speak_position = main_position;
          panel_state = PS_B1_D;
        end else begin
          panel_state = PS_B1_FIN;
        end
      end
      PS_B3_C: begin
        if (repeats_left > 1) begin
          repeats_left--;
          r.siren_cmd = SIREN_STOP;
          if (panel_cfg[CFG_AUDIO_EN][1]) r.speak_vector = VEC_B;
          r.speak_position_valid = 1'b1;
          r.speak_position = main_position;
          panel_state = PS_B3_D;
        end else begin
          panel_state = PS_B3_FIN;
        end
      end
      PS_B1_D: if (poll.audio_idle) panel_state = PS_B1;
      PS_B1_FIN: begin
        r.siren_cmd = SIREN_STOP;
        flood_level = 1'b0;
        aux5_level = 1'b0;
        r.speak_position_valid = 1'b1;
        r.speak_position = main_position;
        panel_state = PS_B1_FIN_B;
      end
      PS_B1_FIN_B, PS_B3_FIN_B: if (poll.audio_idle) r.response = RESP_OK;
      PS_B2: begin
        flood_level = 1'b1;
        panel_state = PS_B2_A;
      end
      PS_B2_A: panel_state = PS_B2_B;
      PS_B2_B: begin
        if (seconds_left == 0) begin
          seconds_left = panel_cfg[CFG_B2_TIMEOUT];
          panel_state = PS_B2_C;
        end
      end
      PS_B2_C: begin
        if (sms) arm_button1(SMS_POSITION);
        if (new_code) begin
          if (poll.button == BTN_2) panel_state = PS_B2_FIN;
          if (poll.button == BTN_1) arm_button1(poll.position[9:0]);
          if (poll.button == BTN_3) arm_button3(poll.position[9:0]);
        end
        if (seconds_left == 0) panel_state = PS_B2_FIN;
      end
      PS_B2_D, PS_B4: begin
        r.siren_cmd = SIREN_STOP;
        r.speak_position_valid = 1'b1;
        r.speak_position = main_position;
        panel_state = (panel_state == PS_B4) ? PS_B4_A : PS_B2_E;
      end
      PS_B2_E: if (poll.audio_idle) panel_state = PS_B2_FIN;
      PS_B4_A: if (poll.audio_idle) panel_state = PS_B4_FIN;
      PS_B2_FIN: begin
        flood_level = 1'b0;
        r.response = RESP_OK;
      end
      PS_B3: begin
        flood_level = 1'b1;
        r.siren_cmd = SIREN_CHOP;
        panel_state = PS_B3_A;
      end
      PS_B3_B: begin
        if (sms) arm_button1(SMS_POSITION);
        if (new_code) begin
          if (poll.button == BTN_3) panel_state = PS_B3_FIN;
          if (poll.button == BTN_1) arm_button1(poll.position[9:0]);
        end
        if (seconds_left == 0) begin
          case (panel_state)
            PS_B1: panel_state = PS_B1_A;
            PS_B3_FIN: panel_state = PS_B3_FIN_B;
            default: panel_state = PS_B3_C;
          endcase
        end
      end
      PS_B3_D: if (poll.audio_idle) panel_state = PS_B3;
      PS_B3_FIN: begin
        r.siren_cmd = SIREN_STOP;
        flood_level = 1'b0;
        r.speak_position_valid = 1'b1;
        r.speak_position = main_position;
        panel_state = PS_B3_FIN_B;
      end
      PS_B4_FIN: r.response = RESP_OK;
      default: panel_state = PS_START;
    endcase

    // seconds timer saturates at zero
    if (poll.second_tick && seconds_left != 0) seconds_left--;
    r.floodlight_on = flood_level;
    r.aux5_on = aux5_level;
    return r;
  endfunction

  function automatic apsq_in_t make_poll_of(input logic [1:0] ev, input logic [15:0] pos,
                                            input logic [7:0] btn, input logic idle,
                                            input logic tick);
    apsq_in_t p;
    p.event_kind = ev;
    p.position = pos;
    p.button = btn;
    p.audio_idle = idle;
    p.second_tick = tick;
    return p;
  endfunction

  // Random poll, steered by the model state so that the programs keep running
  // and switch between each other; a share of pure noise is left unsteered.
  function automatic apsq_in_t make_poll(input bit may_finish);
    apsq_in_t p;
    int roll;
    p.event_kind = 2'($urandom_range(0, 3));
    p.position = 16'($urandom_range(0, 65535));
    p.button = 8'($urandom_range(0, 255));
    p.audio_idle = ($urandom_range(0, 99) < 45);
    p.second_tick = ($urandom_range(0, 99) < 70);
    roll = $urandom_range(0, 99);
    if (roll >= 15) begin
      p.button = 8'($urandom_range(1, 4));
      if ($urandom_range(0, 1)) p.position = 16'($urandom_range(0, 1023));
      case (panel_state)
        PS_B1_B: begin
          if (may_finish && roll < 20) begin
            p.event_kind = EV_NEW;
            p.button = BTN_1;
          end else if (p.event_kind == EV_NEW && p.button == BTN_1) begin
            p.button = BTN_2;
          end
        end
        PS_B2_C: begin
          if (roll < 60) begin
            p.event_kind = EV_NEW;
            p.button = $urandom_range(0, 1) ? BTN_1 : BTN_3;
          end else if (roll < 66) begin
            p.event_kind = EV_SMS;
          end else if (!may_finish && p.event_kind == EV_NEW && p.button == BTN_2) begin
            p.button = BTN_4;
          end
        end
        PS_B3_B: begin
          if (roll < 19) begin
            p.event_kind = (roll < 17) ? EV_SMS : EV_NEW;
            p.button = BTN_1;
          end else if (p.event_kind == EV_NEW && p.button == BTN_1) begin
            p.button = BTN_4;
          end else if (!may_finish && p.event_kind == EV_NEW && p.button == BTN_3) begin
            p.button = BTN_2;
          end
        end
        default: ;
      endcase
    end
    return p;
  endfunction

  function automatic string show_result(input apsq_out_t r);
    return $sformatf("resp=%0d flood=%0d aux5=%0d siren=%0d vec=%0d spk=%0d pos=%0d",
                     r.response, r.floodlight_on, r.aux5_on, r.siren_cmd,
                     r.speak_vector, r.speak_position_valid, r.speak_position);
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, what);
  endtask

  task automatic queue_poll(input apsq_in_t p);
    while (pending_polls.size() >= 2) @(negedge clk);
    pending_polls.push_back(p);
  endtask

  task automatic wait_drained();
    while (pending_polls.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Register write; the model copy follows at the accepting edge
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_AUDIO_EN) panel_cfg[idx] = val & 8'h03;
    else if (idx < CFG_AUDIO_EN) panel_cfg[idx] = val;
  endtask

  task automatic load_settings(input logic [6:0][7:0] vals);
    for (int r = CFG_ARM_DELAY; r <= CFG_AUDIO_EN; r++) write_reg(8'(r), vals[r[2:0]]);
  endtask

  // Input driver: one poll transaction per handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(panel_step(in_data));
      if (!in_valid || in_ready) begin
        if (pending_polls.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= pending_polls.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_failure({"result with no poll waiting: ", show_result(out_data)});
        end else begin
          want_result = expected_results.pop_front();
          if (out_data.response !== want_result.response ||
              out_data.floodlight_on !== want_result.floodlight_on ||
              out_data.aux5_on !== want_result.aux5_on ||
              out_data.siren_cmd !== want_result.siren_cmd ||
              out_data.speak_vector !== want_result.speak_vector ||
              out_data.speak_position_valid !== want_result.speak_position_valid ||
              out_data.speak_position !== want_result.speak_position)
            note_failure({"mismatch: expected ", show_result(want_result),
                          " got ", show_result(out_data)});
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and phase control
  initial begin
    panel_cfg[CFG_ARM_DELAY] = 8'd2;
    panel_cfg[CFG_B1_REPEATS] = 8'd3;
    panel_cfg[CFG_B3_REPEATS] = 8'd3;
    panel_cfg[CFG_B1_TIMEOUT] = 8'd60;
    panel_cfg[CFG_B2_TIMEOUT] = 8'd60;
    panel_cfg[CFG_B3_TIMEOUT] = 8'd60;
    panel_cfg[CFG_AUDIO_EN] = 8'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < 4; phase++) begin
      wait_drained();
      // {audio, b3 timeout, b2 timeout, b1 timeout, b3 repeats, b1 repeats, arm delay}
      case (phase)
        0: phase_regs = {8'h03, 8'd2, 8'd5, 8'd3, 8'd255, 8'd255, 8'd1};
        1: phase_regs = {8'hFC, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0};
        2: phase_regs = {8'hFF, 8'd9, 8'd255, 8'd1, 8'd1, 8'd200, 8'd4};
        default: phase_regs = {8'h02, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255};
      endcase
      load_settings(phase_regs);
      case (phase)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin
          send_idle_pct = 59; stall_pct = 0;
          write_reg(CFG_UNMAPPED, 8'hFF);
          write_reg(CFG_TOP_INDEX, 8'h00);
        end
        2: begin send_idle_pct = 0; stall_pct = 59; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase

      if (phase == 0) begin
        // start state without an alarm, and bad control alarms
        queue_poll(make_poll_of(EV_NEW, 16'd0, BTN_1, 1'b0, 1'b0));
        queue_poll(make_poll_of(EV_NONE, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
        queue_poll(make_poll_of(EV_CTRL, MAX_POSITION + 16'd1, BTN_1, 1'b0, 1'b1));
        queue_poll(make_poll_of(EV_CTRL, 16'hFFFF, BTN_2, 1'b1, 1'b0));
        queue_poll(make_poll_of(EV_CTRL, 16'd5, 8'd0, 1'b0, 1'b0));
        queue_poll(make_poll_of(EV_CTRL, 16'd5, 8'd5, 1'b1, 1'b1));
        queue_poll(make_poll_of(EV_CTRL, 16'd5, 8'hFF, 1'b0, 1'b1));
        // one program entry; the floodlight path leads on to the siren programs
        entry_roll = $urandom_range(0, 99);
        if (entry_roll < 55)
          queue_poll(make_poll_of(EV_CTRL, MAX_POSITION, BTN_2, 1'b0, 1'b0));
        else if (entry_roll < 70)
          queue_poll(make_poll_of(EV_SMS, 16'd0, 8'd0, 1'b1, 1'b0));
        else if (entry_roll < 85)
          queue_poll(make_poll_of(EV_CTRL, 16'd0, BTN_3, 1'b0, 1'b1));
        else
          queue_poll(make_poll_of(EV_CTRL, 16'd700, BTN_4, 1'b0, 1'b0));
      end

      for (n = 0; n < PHASE_POLLS; n++)
        queue_poll(make_poll(phase == 3 && n > PHASE_POLLS / 2));
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
